[rtl/imu_complementary_angle_filter_unit_defines.svh]
// Assertion macros for the angle filter
`ifndef IMU_COMPLEMENTARY_ANGLE_FILTER_UNIT_DEFINES_SVH
`define IMU_COMPLEMENTARY_ANGLE_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define IMUCF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IMUCF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/imucf_pkg.sv]
package imucf_pkg;
	localparam int CORDIC_STEPS    = 16;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int ANGLE_W         = 24;
	localparam int RAW_W           = 16;
	localparam int PRESHIFT        = 14;
	localparam int CW              = 34;
	localparam int ZW              = 32;
	localparam int CNT_W           = 5;
	localparam int ATAN_N          = 24;
	localparam int DIV_STEPS       = 4;
	localparam int ZSH             = 24 - ANGLE_FRAC_BITS;

	localparam int PR1_W = 24;
	localparam int PR2_W = PR1_W + 3 + 16;
	localparam int P_W   = PR2_W + ANGLE_FRAC_BITS + 1;
	localparam int M_W   = P_W - 16;
	localparam int Q_W   = M_W - 14;
	localparam int INC_W = Q_W + 1;
	localparam int SUM_W = ((INC_W > ANGLE_W) ? INC_W : ANGLE_W) + 1;
	localparam int MIX_W = SUM_W + 18;

	localparam logic [15:0] INV_GAIN  = 16'd39797;
	localparam logic [7:0]  GYRO_BASE = 8'd250;
	localparam int          DIV_D     = 32767;
	localparam longint      DIV_HALF  = 64'd32767 * 64'd32768;

	localparam logic [1:0]  GYRO_RANGE_RST = 2'd0;
	localparam logic [15:0] BLEND_RST      = 16'd64225;
	localparam logic [15:0] STEP_TIME_RST  = 16'd328;

	localparam logic signed [ZW-1:0] ATAN_DEG_Q24 [ATAN_N] = '{
		32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
		32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
		32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
		32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
		32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
		32'sd917,       32'sd458,       32'sd229,       32'sd115
	};

	localparam logic signed [MIX_W-1:0] SAT_HI = MIX_W'(2**(ANGLE_W-1) - 1);
	localparam logic signed [MIX_W-1:0] SAT_LO = -SAT_HI - MIX_W'(1);

	typedef enum logic [1:0] {
		REG_GYRO_RANGE = 2'd0,
		REG_BLEND      = 2'd1,
		REG_STEP_TIME  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		AXIS_PITCH = 2'd0,
		AXIS_ROLL  = 2'd1,
		AXIS_YAW   = 2'd2
	} axis_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_LOAD, OP_TILT_INIT, OP_VEC, OP_GAIN, OP_TILT_END,
		OP_GMUL1, OP_GMUL2, OP_GRND, OP_GDIV, OP_GFIX,
		OP_BMUL, OP_BADD, OP_BSTORE, OP_YAW, OP_COMMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		axis_t            axis;
		logic [CNT_W-1:0] idx;
	} dp_cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_TILT_INIT, S_VEC1, S_GAIN, S_VEC2, S_TILT_END,
		S_GMUL1, S_GMUL2, S_GRND, S_GDIV, S_GFIX,
		S_BMUL, S_BADD, S_BSTORE, S_YAW, S_DONE
	} state_t;

	function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [MIX_W-1:0] v);
		logic signed [ANGLE_W-1:0] r;
		if (v > SAT_HI)
			r = ANGLE_W'(SAT_HI);
		else if (v < SAT_LO)
			r = ANGLE_W'(SAT_LO);
		else
			r = ANGLE_W'(v);
		return r;
	endfunction
endpackage

[rtl/imucf_cordic.sv]
module imucf_cordic
	import imucf_pkg::*;
(
	input  logic                 clk,
	input  logic                 load,
	input  logic                 step,
	input  logic signed [CW-1:0] x0,
	input  logic signed [CW-1:0] y0,
	input  logic [CNT_W-1:0]     idx,
	output logic signed [CW-1:0] x,
	output logic signed [ZW-1:0] z
);
	logic signed [CW-1:0] x_q, y_q, xs, ys, xn, yn;
	logic signed [ZW-1:0] z_q, zn;

	always_comb begin
		xs = x_q >>> idx;
		ys = y_q >>> idx;
		if (!y_q[CW-1]) begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + ATAN_DEG_Q24[idx];
		end else begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - ATAN_DEG_Q24[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= '0;
		end else if (step) begin
			x_q <= xn;
			y_q <= yn;
			z_q <= zn;
		end
	end

	assign x = x_q;
	assign z = z_q;
endmodule

[rtl/imucf_dp.sv]
module imucf_dp
	import imucf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	input  logic [6*RAW_W-1:0]        in_data,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_wdata,
	output logic signed [ANGLE_W-1:0] pitch,
	output logic signed [ANGLE_W-1:0] roll,
	output logic signed [ANGLE_W-1:0] yaw
);
	logic [1:0]  gyro_range_sel_q;
	logic [15:0] blend_weight_q, step_time_q;

	logic signed [RAW_W-1:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic signed [ANGLE_W-1:0] pitch_q, roll_q, yaw_q;
	logic signed [ANGLE_W-1:0] new_pitch_q, new_roll_q, new_yaw_q;
	logic signed [ANGLE_W-1:0] acc_pitch_q, acc_roll_q;

	logic             gsign_q;
	logic [PR1_W-1:0] prod1_q;
	logic [PR2_W-1:0] prod2_q;
	logic [M_W-1:0]   m_q;
	logic [Q_W-1:0]   q_q;
	logic signed [INC_W-1:0] inc_q;
	logic signed [MIX_W-1:0] p1_q, p2_q, mix_q;

	logic signed [RAW_W-1:0] num_sel, a_sel, g_sel;
	logic [RAW_W-1:0]        g_abs;
	logic signed [CW-1:0]    b_ext, b_abs, cx0, cy0, cx, mag;
	logic [CW+15:0]          gain_prod;
	logic signed [ZW-1:0]    cz, zabs, zr;
	logic signed [ANGLE_W-1:0] tilt_val, ang_sel, acc_sel, blend_val, yaw_val;
	logic [P_W-1:0]          pw;
	logic [Q_W-1:0]          qf;
	logic signed [SUM_W-1:0] sum, ysum;
	logic [16:0]             wacc;
	logic signed [MIX_W-1:0] mabs, rnd;

	imucf_cordic u_cordic (
		.clk  (clk),
		.load (cmd.op == OP_TILT_INIT || cmd.op == OP_GAIN),
		.step (cmd.op == OP_VEC),
		.x0   (cx0),
		.y0   (cy0),
		.idx  (cmd.idx),
		.x    (cx),
		.z    (cz)
	);

	always_comb begin
		if (cmd.axis == AXIS_PITCH) begin
			num_sel = ax_q;
			a_sel   = ay_q;
			ang_sel = pitch_q;
			acc_sel = acc_pitch_q;
		end else begin
			num_sel = ay_q;
			a_sel   = ax_q;
			ang_sel = roll_q;
			acc_sel = acc_roll_q;
		end
		case (cmd.axis)
			AXIS_PITCH: g_sel = gx_q;
			AXIS_ROLL:  g_sel = gy_q;
			default:    g_sel = gz_q;
		endcase
		g_abs = g_sel[RAW_W-1] ? RAW_W'(-g_sel) : RAW_W'(g_sel);

		b_ext     = CW'(az_q);
		b_abs     = b_ext[CW-1] ? -b_ext : b_ext;
		gain_prod = (CW+16)'($unsigned(cx)) * (CW+16)'(INV_GAIN) + (CW+16)'(32768);
		mag       = CW'(gain_prod >> 16);
		if (cmd.op == OP_GAIN) begin
			cx0 = mag;
			cy0 = CW'(num_sel) <<< PRESHIFT;
		end else begin
			cx0 = b_abs <<< PRESHIFT;
			cy0 = CW'(a_sel) <<< PRESHIFT;
		end

		zabs = cz[ZW-1] ? -cz : cz;
		zr   = (zabs + ZW'(2**(ZSH-1))) >> ZSH;
		if (num_sel == '0)
			tilt_val = '0;
		else if (a_sel == '0 && az_q == '0)
			tilt_val = num_sel[RAW_W-1] ? -ANGLE_W'(90 << ANGLE_FRAC_BITS)
				: ANGLE_W'(90 << ANGLE_FRAC_BITS);
		else
			tilt_val = cz[ZW-1] ? -ANGLE_W'(zr) : ANGLE_W'(zr);

		pw = (P_W'(prod2_q) << ANGLE_FRAC_BITS) + P_W'(DIV_HALF);
		qf = q_q + ((m_q >= M_W'(DIV_D)) ? Q_W'(1) : Q_W'(0));

		sum  = SUM_W'(ang_sel) + SUM_W'(inc_q);
		ysum = SUM_W'(yaw_q) + SUM_W'(inc_q);
		wacc = 17'h10000 - 17'(blend_weight_q);

		mabs      = mix_q[MIX_W-1] ? -mix_q : mix_q;
		rnd       = (mabs + MIX_W'(32768)) >>> 16;
		blend_val = sat_angle(mix_q[MIX_W-1] ? -rnd : rnd);
		yaw_val   = sat_angle(MIX_W'(ysum));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_range_sel_q <= GYRO_RANGE_RST;
			blend_weight_q   <= BLEND_RST;
			step_time_q      <= STEP_TIME_RST;
			pitch_q          <= '0;
			roll_q           <= '0;
			yaw_q            <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_GYRO_RANGE: gyro_range_sel_q <= cfg_wdata[1:0];
					REG_BLEND:      blend_weight_q   <= cfg_wdata;
					REG_STEP_TIME:  step_time_q      <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.op == OP_COMMIT) begin
				pitch_q <= new_pitch_q;
				roll_q  <= new_roll_q;
				yaw_q   <= new_yaw_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ax_q <= in_data[0*RAW_W +: RAW_W];
				ay_q <= in_data[1*RAW_W +: RAW_W];
				az_q <= in_data[2*RAW_W +: RAW_W];
				gx_q <= in_data[3*RAW_W +: RAW_W];
				gy_q <= in_data[4*RAW_W +: RAW_W];
				gz_q <= in_data[5*RAW_W +: RAW_W];
			end
			OP_TILT_END: begin
				if (cmd.axis == AXIS_PITCH)
					acc_pitch_q <= tilt_val;
				else
					acc_roll_q <= tilt_val;
			end
			OP_GMUL1: begin
				gsign_q <= g_sel[RAW_W-1];
				prod1_q <= PR1_W'(g_abs) * PR1_W'(GYRO_BASE);
			end
			OP_GMUL2: prod2_q <= (PR2_W'(prod1_q) << gyro_range_sel_q) * PR2_W'(step_time_q);
			OP_GRND: begin
				m_q <= pw[P_W-1:16];
				q_q <= '0;
			end
			OP_GDIV: begin
				m_q <= (m_q >> 15) + M_W'(m_q[14:0]);
				q_q <= q_q + Q_W'(m_q >> 15);
			end
			OP_GFIX: inc_q <= gsign_q ? -INC_W'(qf) : INC_W'(qf);
			OP_BMUL: begin
				p1_q <= MIX_W'(sum) * MIX_W'($signed({1'b0, blend_weight_q}));
				p2_q <= MIX_W'(acc_sel) * MIX_W'($signed({1'b0, wacc}));
			end
			OP_BADD: mix_q <= p1_q + p2_q;
			OP_BSTORE: begin
				if (cmd.axis == AXIS_PITCH)
					new_pitch_q <= blend_val;
				else
					new_roll_q <= blend_val;
			end
			OP_YAW: new_yaw_q <= yaw_val;
			default: ;
		endcase
	end

	assign pitch = pitch_q;
	assign roll  = roll_q;
	assign yaw   = yaw_q;
endmodule

[rtl/imucf_ctrl.sv]
`include "imu_complementary_angle_filter_unit_defines.svh"

module imucf_ctrl
	import imucf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd
);
	state_t           state_q, state_d;
	axis_t            axis_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             last, out_free;

	assign out_free = !out_valid_q || m_tready;
	assign last = ((state_q == S_VEC1 || state_q == S_VEC2) &&
			cnt_q == CNT_W'(CORDIC_STEPS - 1)) ||
		(state_q == S_GDIV && cnt_q == CNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (s_tvalid) state_d = S_TILT_INIT;
			S_TILT_INIT: state_d = S_VEC1;
			S_VEC1:      if (last) state_d = S_GAIN;
			S_GAIN:      state_d = S_VEC2;
			S_VEC2:      if (last) state_d = S_TILT_END;
			S_TILT_END:  state_d = (axis_q == AXIS_PITCH) ? S_TILT_INIT : S_GMUL1;
			S_GMUL1:     state_d = S_GMUL2;
			S_GMUL2:     state_d = S_GRND;
			S_GRND:      state_d = S_GDIV;
			S_GDIV:      if (last) state_d = S_GFIX;
			S_GFIX:      state_d = (axis_q == AXIS_YAW) ? S_YAW : S_BMUL;
			S_BMUL:      state_d = S_BADD;
			S_BADD:      state_d = S_BSTORE;
			S_BSTORE:    state_d = S_GMUL1;
			S_YAW:       state_d = S_DONE;
			S_DONE:      if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.axis = axis_q;
		cmd.idx  = cnt_q;
		unique case (state_q)
			S_IDLE:      cmd.op = s_tvalid ? OP_LOAD : OP_NOP;
			S_TILT_INIT: cmd.op = OP_TILT_INIT;
			S_VEC1:      cmd.op = OP_VEC;
			S_GAIN:      cmd.op = OP_GAIN;
			S_VEC2:      cmd.op = OP_VEC;
			S_TILT_END:  cmd.op = OP_TILT_END;
			S_GMUL1:     cmd.op = OP_GMUL1;
			S_GMUL2:     cmd.op = OP_GMUL2;
			S_GRND:      cmd.op = OP_GRND;
			S_GDIV:      cmd.op = OP_GDIV;
			S_GFIX:      cmd.op = OP_GFIX;
			S_BMUL:      cmd.op = OP_BMUL;
			S_BADD:      cmd.op = OP_BADD;
			S_BSTORE:    cmd.op = OP_BSTORE;
			S_YAW:       cmd.op = OP_YAW;
			S_DONE:      cmd.op = out_free ? OP_COMMIT : OP_NOP;
			default:     cmd.op = OP_NOP;
		endcase
		s_tready = (state_q == S_IDLE);
		m_tvalid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= AXIS_PITCH;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			unique case (state_q) inside
				S_VEC1, S_VEC2, S_GDIV: cnt_q <= last ? '0 : cnt_q + CNT_W'(1);
				default:                cnt_q <= '0;
			endcase

			case (state_q)
				S_IDLE:     axis_q <= AXIS_PITCH;
				S_TILT_END: axis_q <= (axis_q == AXIS_PITCH) ? AXIS_ROLL : AXIS_PITCH;
				S_BSTORE:   axis_q <= (axis_q == AXIS_PITCH) ? AXIS_ROLL : AXIS_YAW;
				default: ;
			endcase

			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	`IMUCF_ASSERT_IMP(a_commit_free, clk, arst_n, cmd.op == OP_COMMIT, out_free, "commit while output busy")
	`IMUCF_ASSERT_NEXT(a_load_start, clk, arst_n, cmd.op == OP_LOAD, state_q == S_TILT_INIT, "load did not start tilt")
	`IMUCF_ASSERT_IMP(a_cnt_range, clk, arst_n, state_q == S_VEC1 || state_q == S_VEC2, cnt_q < CNT_W'(CORDIC_STEPS), "cordic step out of range")
	`IMUCF_ASSERT_IMP(a_valid_src, clk, arst_n, $rose(out_valid_q), $past(state_q == S_DONE), "result without commit")
endmodule

[rtl/imu_complementary_angle_filter_unit.sv]
// Complementary pitch/roll/yaw filter for a six-axis IMU.
// Input channel (s_axis_*): one transaction carries one raw sample of
// accel x/y/z and gyro x/y/z, each signed 16 bits.
// Output channel (m_axis_*): one transaction per sample with the filtered
// pitch, roll and yaw, signed 24 bits in 1/256 degree, saturating.
// Configuration (cfg_*): index 0 gyro range select, 1 gyro blend weight
// (Q0.16), 2 sample period (Q0.16 seconds). Write only while idle.
// The shared CORDIC unit runs two vectoring passes per tilt angle, one
// step per cycle, and the gyro scaling runs a four-step divide by 32767
// per axis. A new sample is accepted only while idle, after the previous
// result has been committed to the output register.
// The output register holds the stored angles; if the receiver stalls, a
// new sample is still accepted and computed, and waits until the previous
// result is taken. Reset clears all three angles to zero and restores the
// register defaults (range 0, weight 64225, period 328).
module imu_complementary_angle_filter_unit
	import imucf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	input  logic [6*RAW_W-1:0]   s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// pitch, roll, yaw
	output logic [3*ANGLE_W-1:0] m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);
	dp_cmd_t cmd;
	logic signed [ANGLE_W-1:0] pitch, roll, yaw;

	imucf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.cmd      (cmd)
	);

	imucf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pitch     (pitch),
		.roll      (roll),
		.yaw       (yaw)
	);

	assign m_axis_tdata = {yaw, roll, pitch};
endmodule
